FILE: hdl/hsv2rgb_pkg.sv
// Shared constants and pipeline stage types for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int InW    = 12;
  localparam int MagW   = 11;
  localparam int FracW  = 9;
  localparam int V255W  = 18;
  localparam int NfW    = 19;
  localparam int PmW    = V255W + MagW;
  localparam int PnW    = V255W + NfW;
  localparam int ChanW  = 8;

  localparam logic [MagW-1:0]  UnitSv    = 11'd1024;
  localparam logic [MagW-1:0]  HueMax    = 11'd1536;
  localparam logic [FracW-1:0] HueSteps  = 9'd256;
  localparam logic [NfW-1:0]   UnitSvHue = 19'd262144;

  localparam logic [2:0] Sec1 = 3'd1;
  localparam logic [2:0] Sec2 = 3'd2;
  localparam logic [2:0] Sec3 = 3'd3;
  localparam logic [2:0] Sec4 = 3'd4;
  localparam logic [2:0] Sec5 = 3'd5;

  typedef struct packed {
    logic             black;
    logic             grey;
    logic [2:0]       sector;
    logic [FracW-1:0] frac;
    logic [MagW-1:0]  v;
    logic [MagW-1:0]  s;
  } stage1_t;

  typedef struct packed {
    logic              black;
    logic              grey;
    logic [2:0]        sector;
    logic [V255W-1:0]  v255;
    logic [MagW-1:0]   oms;
    logic [NfW-1:0]    nf;
  } stage2_t;

  typedef struct packed {
    logic             black;
    logic             grey;
    logic [2:0]       sector;
    logic [ChanW-1:0] cv;
    logic [PmW-1:0]   pm;
    logic [PnW-1:0]   pn;
  } stage3_t;

endpackage

FILE: hdl/hsv_to_rgb_converter.sv
// Four-stage pipelined HSV to RGB color converter.
`timescale 1ns / 1ps

// Usage:
//   Input: drive in_hue_sectors, in_saturation and in_brightness and pulse
//   start. A beat is taken at every edge with start high and busy low; busy
//   is always low, so a new color can enter every cycle.
//   Output: out_valid is high for one cycle with out_red, out_green and
//   out_blue; the beat is taken at the edge ending that cycle. The receiver
//   cannot stall the block, so no backpressure exists.
//   Throughput: 1 color per cycle, set by the four register stages
//   (range check and fraction, 255*v and s*f, the two wide products,
//   channel select).
//   Reset: synchronous, active-low rst_n clears all stage valid bits; beats
//   in flight are dropped, payload registers are left as they are.
//   Saturation or brightness outside 0..1024 gives black; hue outside
//   0..1536 gives grey at 255*v/1024.
module hsv_to_rgb_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic signed [11:0] in_hue_sectors,
  input  logic signed [11:0] in_saturation,
  input  logic signed [11:0] in_brightness,
  output logic              out_valid,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue
);

  logic                   acc;
  logic                   s_ok, v_ok, h_ok;
  logic [2:0]             sec_in;
  logic [hsv2rgb_pkg::FracW-1:0] frac_in;

  logic                   vld1_r, vld2_r, vld3_r, vld4_r;
  hsv2rgb_pkg::stage1_t   st1_r, st1_nxt;
  hsv2rgb_pkg::stage2_t   st2_r, st2_nxt;
  hsv2rgb_pkg::stage3_t   st3_r, st3_nxt;
  logic [7:0]             red_r, green_r, blue_r;
  logic [7:0]             red_nxt, green_nxt, blue_nxt;

  logic [18:0]            v256;
  logic [18:0]            sf;
  logic [7:0]             cm, cn;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // stage 1: range checks, sector and fraction
  always_comb begin
    s_ok    = !in_saturation[11] && (in_saturation[10:0] <= hsv2rgb_pkg::UnitSv);
    v_ok    = !in_brightness[11] && (in_brightness[10:0] <= hsv2rgb_pkg::UnitSv);
    h_ok    = !in_hue_sectors[11] && (in_hue_sectors[10:0] <= hsv2rgb_pkg::HueMax);
    sec_in  = in_hue_sectors[10:8];
    frac_in = {1'b0, in_hue_sectors[7:0]};
    if (!sec_in[0]) begin
      frac_in = hsv2rgb_pkg::HueSteps - frac_in;
    end
    st1_nxt.black  = !(s_ok && v_ok);
    st1_nxt.grey   = !h_ok;
    st1_nxt.sector = sec_in;
    st1_nxt.frac   = frac_in;
    st1_nxt.v      = in_brightness[10:0];
    st1_nxt.s      = in_saturation[10:0];
  end

  // stage 2: 255*v, 1-s, 1-s*f
  always_comb begin
    v256           = {st1_r.v, 8'd0};
    sf             = {8'd0, st1_r.s} * {10'd0, st1_r.frac};
    st2_nxt.black  = st1_r.black;
    st2_nxt.grey   = st1_r.grey;
    st2_nxt.sector = st1_r.sector;
    st2_nxt.v255   = 18'(v256 - {8'd0, st1_r.v});
    st2_nxt.oms    = hsv2rgb_pkg::UnitSv - st1_r.s;
    st2_nxt.nf     = hsv2rgb_pkg::UnitSvHue - sf;
  end

  // stage 3: wide products
  always_comb begin
    st3_nxt.black  = st2_r.black;
    st3_nxt.grey   = st2_r.grey;
    st3_nxt.sector = st2_r.sector;
    st3_nxt.cv     = st2_r.v255[17:10];
    st3_nxt.pm     = {11'd0, st2_r.v255} * {18'd0, st2_r.oms};
    st3_nxt.pn     = {19'd0, st2_r.v255} * {18'd0, st2_r.nf};
  end

  // stage 4: scale, channel select, grey and black override
  always_comb begin
    cm = st3_r.pm[27:20];
    cn = st3_r.pn[35:28];
    case (st3_r.sector)
      hsv2rgb_pkg::Sec1: begin
        red_nxt = cn;       green_nxt = st3_r.cv; blue_nxt = cm;
      end
      hsv2rgb_pkg::Sec2: begin
        red_nxt = cm;       green_nxt = st3_r.cv; blue_nxt = cn;
      end
      hsv2rgb_pkg::Sec3: begin
        red_nxt = cm;       green_nxt = cn;       blue_nxt = st3_r.cv;
      end
      hsv2rgb_pkg::Sec4: begin
        red_nxt = cn;       green_nxt = cm;       blue_nxt = st3_r.cv;
      end
      hsv2rgb_pkg::Sec5: begin
        red_nxt = st3_r.cv; green_nxt = cm;       blue_nxt = cn;
      end
      default: begin
        red_nxt = st3_r.cv; green_nxt = cn;       blue_nxt = cm;
      end
    endcase
    if (st3_r.grey) begin
      red_nxt   = st3_r.cv;
      green_nxt = st3_r.cv;
      blue_nxt  = st3_r.cv;
    end
    if (st3_r.black) begin
      red_nxt   = 8'd0;
      green_nxt = 8'd0;
      blue_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= acc;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    st1_r   <= st1_nxt;
    st2_r   <= st2_nxt;
    st3_r   <= st3_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = vld4_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted beat did not reach the output after 4 cycles");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("output strobe without a matching accepted beat");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_saturation[11] || in_brightness[11] ||
      (in_saturation[10:0] > hsv2rgb_pkg::UnitSv) ||
      (in_brightness[10:0] > hsv2rgb_pkg::UnitSv)))
    |-> ##4 (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("out-of-range saturation or value did not give black");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(st3_r.grey, 1)) |-> (out_red == out_green && out_green == out_blue))
    else $error("out-of-range hue did not give grey");

endmodule

FILE: dv/hsv_to_rgb_converter_tb.sv
// Self-checking testbench for the pipelined HSV to RGB color converter.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

  typedef struct packed {
    logic [hsv2rgb_pkg::InW-1:0] hue;
    logic [hsv2rgb_pkg::InW-1:0] sat;
    logic [hsv2rgb_pkg::InW-1:0] val;
  } hsv_t;

  typedef struct packed {
    logic [hsv2rgb_pkg::ChanW-1:0] red;
    logic [hsv2rgb_pkg::ChanW-1:0] green;
    logic [hsv2rgb_pkg::ChanW-1:0] blue;
  } rgb_t;

  localparam int FullScale  = 1024;
  localparam int HueTop     = 1536;
  localparam int SectorSize = 256;
  localparam int IdlePct    = 31;
  localparam int RandBeats  = 600;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [hsv2rgb_pkg::InW-1:0] in_hue_sectors = '0;
  logic signed [hsv2rgb_pkg::InW-1:0] in_saturation = '0;
  logic signed [hsv2rgb_pkg::InW-1:0] in_brightness = '0;
  logic out_valid;
  logic [hsv2rgb_pkg::ChanW-1:0] out_red;
  logic [hsv2rgb_pkg::ChanW-1:0] out_green;
  logic [hsv2rgb_pkg::ChanW-1:0] out_blue;

  hsv_t hsv_pending[$];
  rgb_t rgb_expected[$];
  hsv_t hsv_driven;

  int beats_in = 0;
  int beats_out = 0;
  int black_cnt = 0;
  int grey_cnt = 0;
  int color_cnt = 0;
  int error_cnt = 0;
  int cycle_cnt = 0;

  hsv_to_rgb_converter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_hue_sectors (in_hue_sectors),
    .in_saturation  (in_saturation),
    .in_brightness  (in_brightness),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic rgb_t predict_rgb(hsv_t c);
    int h, s, v;
    longint unsigned lv, ls, frac, cv, cm, cn;
    logic [2:0] sec;
    rgb_t r;
    h = int'($signed(c.hue));
    s = int'($signed(c.sat));
    v = int'($signed(c.val));
    r = '0;
    if (s >= 0 && s <= FullScale && v >= 0 && v <= FullScale) begin
      lv = longint'(v);
      ls = longint'(s);
      cv = (255 * lv) >> 10;
      if (h < 0 || h > HueTop) begin
        r = '{cv[7:0], cv[7:0], cv[7:0]};
      end else begin
        sec = 3'(h / SectorSize);
        frac = longint'(h % SectorSize);
        if (!sec[0]) frac = SectorSize - frac;
        cm = (255 * lv * (FullScale - ls)) >> 20;
        cn = (255 * lv * (FullScale * SectorSize - ls * frac)) >> 28;
        case (sec)
          hsv2rgb_pkg::Sec1: r = '{cn[7:0], cv[7:0], cm[7:0]};
          hsv2rgb_pkg::Sec2: r = '{cm[7:0], cv[7:0], cn[7:0]};
          hsv2rgb_pkg::Sec3: r = '{cm[7:0], cn[7:0], cv[7:0]};
          hsv2rgb_pkg::Sec4: r = '{cn[7:0], cm[7:0], cv[7:0]};
          hsv2rgb_pkg::Sec5: r = '{cv[7:0], cm[7:0], cn[7:0]};
          default: r = '{cv[7:0], cn[7:0], cm[7:0]};
        endcase
      end
    end
    return r;
  endfunction

  function automatic void classify(hsv_t c);
    int h, s, v;
    h = int'($signed(c.hue));
    s = int'($signed(c.sat));
    v = int'($signed(c.val));
    if (s < 0 || s > FullScale || v < 0 || v > FullScale) black_cnt++;
    else if (h < 0 || h > HueTop) grey_cnt++;
    else color_cnt++;
  endfunction

  function automatic void queue_hsv(int h, int s, int v);
    hsv_t c;
    c.hue = hsv2rgb_pkg::InW'(h);
    c.sat = hsv2rgb_pkg::InW'(s);
    c.val = hsv2rgb_pkg::InW'(v);
    hsv_pending.push_back(c);
  endfunction

  // saturation / brightness: mostly in range, edges and junk mixed in
  function automatic int pick_level();
    int edges[6] = '{0, 1, 1023, 1024, 1025, -1};
    case ($urandom_range(9))
      0: return int'($signed(hsv2rgb_pkg::InW'($urandom_range(4095))));
      1: return edges[$urandom_range(5)];
      default: return $urandom_range(FullScale);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    logic idle;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rgb_expected.push_back(predict_rgb(hsv_driven));
        classify(hsv_driven);
        beats_in++;
      end
      idle = (beats_in >= 250 && beats_in < 400) ? 1'b0 : ($urandom_range(99) < IdlePct);
      if (start && busy) begin
        start <= 1'b1;
      end else if (hsv_pending.size() != 0 && !idle) begin
        hsv_driven = hsv_pending.pop_front();
        in_hue_sectors <= hsv_driven.hue;
        in_saturation <= hsv_driven.sat;
        in_brightness <= hsv_driven.val;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rgb_t exp_rgb;
    if (rst_n && out_valid === 1'b1) begin
      beats_out++;
      if (rgb_expected.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("[%0t] unexpected beat r=%0d g=%0d b=%0d", $realtime,
                   out_red, out_green, out_blue);
      end else begin
        exp_rgb = rgb_expected.pop_front();
        if (out_red !== exp_rgb.red || out_green !== exp_rgb.green ||
            out_blue !== exp_rgb.blue) begin
          error_cnt++;
          if (error_cnt <= 10) begin
            if (out_red !== exp_rgb.red)
              $display("[%0t] beat %0d red: exp %0d got %0d", $realtime, beats_out,
                       exp_rgb.red, out_red);
            if (out_green !== exp_rgb.green)
              $display("[%0t] beat %0d green: exp %0d got %0d", $realtime, beats_out,
                       exp_rgb.green, out_green);
            if (out_blue !== exp_rgb.blue)
              $display("[%0t] beat %0d blue: exp %0d got %0d", $realtime, beats_out,
                       exp_rgb.blue, out_blue);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               rgb_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int h;
    // directed: every sector, boundaries, grey and black corners
    queue_hsv(0, 1024, 1024);
    queue_hsv(128, 1024, 1024);
    queue_hsv(256, 1024, 1024);
    queue_hsv(384, 1024, 1024);
    queue_hsv(640, 1024, 1024);
    queue_hsv(767, 0, 1024);
    queue_hsv(768, 1024, 1024);
    queue_hsv(896, 512, 1024);
    queue_hsv(1152, 1024, 700);
    queue_hsv(1280, 300, 1024);
    queue_hsv(1535, 1024, 1024);
    queue_hsv(1536, 1024, 1024);
    queue_hsv(1537, 512, 1024);
    queue_hsv(-1, 512, 1024);
    queue_hsv(-2048, 1024, 1024);
    queue_hsv(2047, 0, 512);
    queue_hsv(0, -1, 1024);
    queue_hsv(0, 1025, 1024);
    queue_hsv(0, 512, -1);
    queue_hsv(0, 512, 1025);
    queue_hsv(100, -2048, 2047);
    queue_hsv(2047, 2047, -2048);
    queue_hsv(0, 0, 0);
    queue_hsv(300, 1024, 0);
    queue_hsv(1408, 1, 1);

    repeat (RandBeats) begin
      case ($urandom_range(9))
        0: h = int'($signed(hsv2rgb_pkg::InW'($urandom_range(4095))));
        1: h = $urandom_range(6) * SectorSize + $urandom_range(2) - 1;
        2: h = $urandom_range(2) == 0 ? -$urandom_range(2) - 1 : HueTop + $urandom_range(2);
        default: h = $urandom_range(HueTop);
      endcase
      queue_hsv(h, pick_level(), pick_level());
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (hsv_pending.size() != 0 || start) @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    error_cnt += rgb_expected.size();
    $display("%0d colors sent, %0d checked: %0d in range, %0d grey, %0d black",
             beats_in, beats_out, color_cnt, grey_cnt, black_cnt);
    $display("%0d failures in %0d cycles", error_cnt, cycle_cnt);
    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/hsv2rgb_pkg.sv
hdl/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_tb.sv
